FILE: src/ack_nak_byte_link_macros.svh
// Assertion macros for the stop-and-wait byte link.
`ifndef ACK_NAK_BYTE_LINK_MACROS_SVH
`define ACK_NAK_BYTE_LINK_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ANBL_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ANBL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/anbl_pkg.sv
// Shared types and constants of the stop-and-wait byte link.
`timescale 1ns / 1ps

package anbl_pkg;

	localparam logic [7:0] ACK_CODE = 8'hFE;
	localparam logic [7:0] NAK_CODE = 8'hDE;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		REQ_QUEUE = 2'd0,
		REQ_RX    = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_TXRDY = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CTL_NONE = 2'd0,
		CTL_ACK  = 2'd1,
		CTL_NAK  = 2'd2
	} ctl_t;

	typedef struct packed {
		logic       queue_full;
		logic       link_fail;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [7:0] tx_byte;
		logic       tx_valid;
	} result_t;

	typedef struct packed {
		logic awaiting;
		logic empty;
	} status_t;

	function automatic logic is_control(input logic [7:0] b);
		return (b == ACK_CODE) || (b == NAK_CODE);
	endfunction

endpackage

FILE: src/anbl_store.sv
// Send queue storage: one write port, one registered read port with bypass.
`timescale 1ns / 1ps

module anbl_store import anbl_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [IW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// a byte queued into an empty queue becomes the head at once
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/anbl_ctrl.sv
// Link control: queue pointers, reply wait, timer and pending ACK/NAK.
`timescale 1ns / 1ps

module anbl_ctrl import anbl_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int IW = 4,
	parameter int FW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          acc,
	input  req_t          req,
	input  logic [7:0]    byte_in,
	input  logic          err,
	input  logic [7:0]    head_byte,
	output logic          st_we,
	output logic [IW-1:0] st_waddr,
	output logic [7:0]    st_wdata,
	output logic [IW-1:0] st_raddr,
	output result_t       res,
	output status_t       status
);

	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

	logic [IW-1:0] head_q, head_d, tail_q, tail_d;
	logic [FW-1:0] fill_q, fill_d;
	logic          awaiting_q, awaiting_d;
	logic          resend_q, resend_d;
	logic [15:0]   timer_q, timer_d;
	ctl_t          ctl_q, ctl_d;
	logic [15:0]   timeout_q;
	logic [IW-1:0] head_inc, tail_inc;
	logic          empty, full;

	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + IW'(1);
	assign empty = (fill_q == '0);
	assign full = (fill_q == DEPTH_F);

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		fill_d = fill_q;
		awaiting_d = awaiting_q;
		resend_d = resend_q;
		timer_d = timer_q;
		ctl_d = ctl_q;
		res = '0;
		st_we = 1'b0;
		if (acc) begin
			case (req)
				REQ_QUEUE: begin
					if (!full) begin
						st_we = 1'b1;
						tail_d = tail_inc;
						fill_d = fill_q + FW'(1);
					end else begin
						res.queue_full = 1'b1;
					end
				end
				REQ_RX: begin
					if (is_control(byte_in)) begin
						if (!err && awaiting_q) begin
							if (byte_in == ACK_CODE) begin
								if (!empty) begin
									head_d = head_inc;
									fill_d = fill_q - FW'(1);
								end
								awaiting_d = 1'b0;
								resend_d = 1'b0;
								timer_d = '0;
							end else begin
								resend_d = 1'b1;
							end
						end
					end else if (err) begin
						ctl_d = CTL_NAK;
					end else begin
						res.rx_valid = 1'b1;
						res.rx_byte = byte_in;
						ctl_d = CTL_ACK;
					end
				end
				REQ_TICK: begin
					if (awaiting_q) begin
						if (timer_q <= 16'd1) begin
							timer_d = '0;
							awaiting_d = 1'b0;
							resend_d = 1'b1;
							res.link_fail = 1'b1;
						end else begin
							timer_d = timer_q - 16'd1;
						end
					end
				end
				REQ_TXRDY: begin
					if (ctl_q != CTL_NONE) begin
						res.tx_valid = 1'b1;
						res.tx_byte = (ctl_q == CTL_NAK) ? NAK_CODE : ACK_CODE;
						ctl_d = CTL_NONE;
					end else if (resend_q) begin
						resend_d = 1'b0;
						if (!empty) begin
							res.tx_valid = 1'b1;
							res.tx_byte = head_byte;
						end
					end else if (!awaiting_q && !empty) begin
						res.tx_valid = 1'b1;
						res.tx_byte = head_byte;
						// control codes in the queue go out unacknowledged
						if (is_control(head_byte)) begin
							head_d = head_inc;
							fill_d = fill_q - FW'(1);
						end else begin
							awaiting_d = 1'b1;
							timer_d = timeout_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign st_waddr = tail_q;
	assign st_wdata = byte_in;
	// read ahead at the next head so the head byte is ready for the next item
	assign st_raddr = head_d;
	assign status.awaiting = awaiting_q;
	assign status.empty = empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			awaiting_q <= 1'b0;
			resend_q <= 1'b0;
			timer_q <= '0;
			ctl_q <= CTL_NONE;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
			awaiting_q <= awaiting_d;
			resend_q <= resend_d;
			timer_q <= timer_d;
			ctl_q <= ctl_d;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

endmodule

FILE: src/ack_nak_byte_link.sv
// Stop-and-wait byte link over a UART: top level with the result register.
//
// Input channel s_*: one item per UART event. s_tuser carries the event kind
// (queue a byte, byte received, timer tick, transmitter ready); s_tdata
// carries the byte and its line error flag. Output channel m_*: exactly one
// result item per input item, holding the byte for the transmitter, the
// delivered byte, and the link failure and queue full flags.
// An item is accepted, the link state updates and its result is in the
// output register in the cycle after; one item per cycle is sustained
// while the receiver takes each result. The send queue's head byte is read
// ahead from the queue memory, so the single read port sets no limit.
// The timeout register is written through cfg_we/cfg_wdata, by the user
// only while idle; the block does not enforce it. Reset empties the queue,
// clears the wait, the timer and any pending ACK/NAK, and loads the timeout
// with 1000 ticks; the queue memory is not cleared, needing no clearing pass.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken; with the register draining, a new item
// is accepted in the same cycle.
`timescale 1ns / 1ps
`include "ack_nak_byte_link_macros.svh"

module ack_nak_byte_link import anbl_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte[7:0], line_error[8], zero[15:9]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// tx_valid[0], tx_byte[8:1], rx_valid[9], rx_byte[17:10],
	// link_fail[18], queue_full[19], zero[23:20]
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	logic          acc;
	logic          st_we;
	logic [IW-1:0] st_waddr, st_raddr;
	logic [7:0]    st_wdata, head_byte;
	result_t       res, res_q;
	status_t       status;
	logic          out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign acc = s_tvalid && s_tready;

	anbl_ctrl #(
		.DEPTH(QUEUE_DEPTH),
		.IW(IW),
		.FW(FW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.acc(acc),
		.req(req_t'(s_tuser)),
		.byte_in(s_tdata[7:0]),
		.err(s_tdata[8]),
		.head_byte(head_byte),
		.st_we(st_we),
		.st_waddr(st_waddr),
		.st_wdata(st_wdata),
		.st_raddr(st_raddr),
		.res(res),
		.status(status)
	);

	anbl_store #(
		.DEPTH(QUEUE_DEPTH),
		.IW(IW)
	) u_store (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(head_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0, res_q};

	`ANBL_ASSERT_NEXT(a_item_gives_result, acc, m_tvalid, "accepted item left no result")
	`ANBL_ASSERT_HOLDS(a_one_event_kind, m_tvalid,
		$countones({m_tdata[0], m_tdata[9], m_tdata[18], m_tdata[19]}) <= 1,
		"result flags from more than one event kind")
	`ANBL_ASSERT_HOLDS(a_wait_has_head, status.awaiting, !status.empty,
		"waiting for a reply with an empty send queue")

endmodule
